FILE: rtl/rtv_pkg.sv
// rtv_pkg: shared types, constants and the magic table for the resource table validator
// used by rtv_front, rtv_queue, rtv_back and resource_table_validator_unit
// no dependencies
`default_nettype none

package rtv_pkg;

  // container layout
  localparam int unsigned HEADER_BYTES = 24;
  localparam int unsigned ENTRY_BYTES  = 264;
  localparam int unsigned NAME_BYTES   = 256;
  localparam int unsigned MAGIC_BYTES  = 10;
  localparam int unsigned COUNT_POS    = 20;

  // defaults for top-level parameters
  localparam int unsigned MAX_ENTRIES_DEF = 200000;
  localparam int unsigned Q_DEPTH_DEF     = 2;

  // field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned POS_W   = 9;
  localparam int unsigned IDX_W   = 18;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned SIZE_W  = 32;
  localparam int unsigned OFF_W   = 32;
  localparam int unsigned CHAIN_W = 33;
  localparam int unsigned SPAN_W  = 48;
  localparam int unsigned FPOS_W  = 49;
  localparam int unsigned TSIZE_W = 41;
  localparam int unsigned DS_W    = 42;
  localparam int unsigned ADDR_W  = 4;
  localparam int unsigned DATA_W  = 64;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_SPAN_SHORT = 3'd1,
    ST_BAD_MAGIC  = 3'd2,
    ST_BAD_COUNT  = 3'd3,
    ST_TABLE_BIG  = 3'd4,
    ST_CHAIN_BAD  = 3'd5,
    ST_OVERRUN    = 3'd6
  } status_t;

  // register index, taken from paddr bit 3
  typedef enum logic [0:0] {
    REG_FILE_SPAN   = 1'b0,
    REG_BASE_OFFSET = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              start_flag;
  } in_item_t;

  typedef struct packed {
    status_t           status;
    logic [IDX_W-1:0]  entry_index;
    logic [SIZE_W-1:0] entry_size;
    logic [FPOS_W-1:0] data_position;
    logic [FPOS_W-1:0] table_position;
    logic              final_entry;
  } out_item_t;

  // classified transaction handed from front to back
  typedef struct packed {
    status_t           status;
    logic [IDX_W-1:0]  entry_index;
    logic [SIZE_W-1:0] entry_size;
    logic [OFF_W-1:0]  rel_offset;
    logic [DS_W-1:0]   data_start;
    logic              final_entry;
  } q_item_t;

  // expected header magic "|CCTfs2.0|" style string, byte by byte
  function automatic logic [BYTE_W-1:0] magic_byte(input logic [3:0] idx);
    logic [BYTE_W-1:0] val;
    unique case (idx)
      4'd0:    val = 8'h7C;
      4'd1:    val = 8'h43;
      4'd2:    val = 8'h43;
      4'd3:    val = 8'h54;
      4'd4:    val = 8'h66;
      4'd5:    val = 8'h73;
      4'd6:    val = 8'h32;
      4'd7:    val = 8'h2E;
      4'd8:    val = 8'h30;
      4'd9:    val = 8'h7C;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/rtv_front.sv
// rtv_front: byte parser; tracks header and table position, assembles fields,
// makes every check and pushes one classified transaction per result
// depends on rtv_pkg
`default_nettype none

module rtv_front #(
  parameter int unsigned MAX_ENTRIES = rtv_pkg::MAX_ENTRIES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  input  wire rtv_pkg::in_item_t             in_item,
  output logic                               in_stall,
  input  wire logic [rtv_pkg::SPAN_W-1:0]    file_span,
  input  wire logic                          q_full,
  output logic                               q_push,
  output rtv_pkg::q_item_t                   q_item
);

  localparam int unsigned POS_W   = rtv_pkg::POS_W;
  localparam int unsigned CNT_W   = rtv_pkg::CNT_W;
  localparam int unsigned IDX_W   = rtv_pkg::IDX_W;
  localparam int unsigned CHAIN_W = rtv_pkg::CHAIN_W;
  localparam int unsigned DS_W    = rtv_pkg::DS_W;
  localparam int unsigned TSIZE_W = rtv_pkg::TSIZE_W;
  localparam int unsigned SPAN_W  = rtv_pkg::SPAN_W;
  localparam int unsigned FPOS_W  = rtv_pkg::FPOS_W;

  localparam logic [POS_W-1:0] POS_MAGIC_END = POS_W'(rtv_pkg::MAGIC_BYTES);
  localparam logic [POS_W-1:0] POS_CNT_LO    = POS_W'(rtv_pkg::COUNT_POS);
  localparam logic [POS_W-1:0] POS_HDR_LAST  = POS_W'(rtv_pkg::HEADER_BYTES - 1);
  localparam logic [POS_W-1:0] POS_SIZE_LO   = POS_W'(rtv_pkg::NAME_BYTES);
  localparam logic [POS_W-1:0] POS_OFF_LO    = POS_W'(rtv_pkg::NAME_BYTES + 4);
  localparam logic [POS_W-1:0] POS_ENT_LAST  = POS_W'(rtv_pkg::ENTRY_BYTES - 1);

  // parse state
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic               in_table_r, in_table_nxt;
  logic [IDX_W-1:0]   ent_r, ent_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [31:0]        size_r, size_nxt;
  logic [31:0]        off_r, off_nxt;
  logic [CHAIN_W-1:0] chain_r, chain_nxt;
  logic               halted_r, halted_nxt;
  logic [DS_W-1:0]    ds_r, ds_nxt;

  // state as seen by this byte, after a restart
  logic               acc, start;
  logic [7:0]         b;
  logic [POS_W-1:0]   cur_pos;
  logic               cur_in_table;
  logic [IDX_W-1:0]   cur_ent;
  logic [CNT_W-1:0]   cur_count;
  logic [31:0]        cur_size, cur_off;
  logic [CHAIN_W-1:0] cur_chain;
  logic               cur_halted;

  logic [CNT_W-1:0]   cnt_now;
  logic [31:0]        size_now, off_now;
  logic [TSIZE_W-1:0] tsize;
  logic [DS_W-1:0]    ds_now;
  logic [FPOS_W-1:0]  end_sum;
  logic               span_short, magic_bad, err_count, err_table;
  logic               err_chain, err_over, last;

  assign in_stall = q_full;
  assign acc      = in_valid && !q_full;
  assign start    = in_item.start_flag;
  assign b        = in_item.data_byte;

  // restart clears parse state before the byte is looked at
  always_comb begin
    cur_pos      = start ? '0 : pos_r;
    cur_in_table = start ? 1'b0 : in_table_r;
    cur_ent      = start ? '0 : ent_r;
    cur_count    = start ? '0 : count_r;
    cur_size     = start ? '0 : size_r;
    cur_off      = start ? '0 : off_r;
    cur_chain    = start ? '0 : chain_r;
    cur_halted   = start ? 1'b0 : halted_r;
  end

  // field assembly, little-endian lanes from the low position bits
  always_comb begin
    cnt_now  = cur_count;
    size_now = cur_size;
    off_now  = cur_off;
    if (cur_pos >= POS_CNT_LO && cur_pos <= POS_HDR_LAST) begin
      cnt_now[{cur_pos[1:0], 3'b000} +: 8] = cur_count[{cur_pos[1:0], 3'b000} +: 8] | b;
    end
    if (cur_pos >= POS_SIZE_LO && cur_pos < POS_OFF_LO) begin
      if (cur_pos == POS_SIZE_LO) begin
        size_now = '0;
      end
      size_now[{cur_pos[1:0], 3'b000} +: 8] = size_now[{cur_pos[1:0], 3'b000} +: 8] | b;
    end
    if (cur_pos >= POS_OFF_LO && cur_pos <= POS_ENT_LAST) begin
      if (cur_pos == POS_OFF_LO) begin
        off_now = '0;
      end
      off_now[{cur_pos[1:0], 3'b000} +: 8] = off_now[{cur_pos[1:0], 3'b000} +: 8] | b;
    end
  end

  // header checks
  always_comb begin
    span_short = start && (file_span < SPAN_W'(rtv_pkg::HEADER_BYTES));
    magic_bad  = (cur_pos < POS_MAGIC_END) && (b != rtv_pkg::magic_byte(cur_pos[3:0]));
    tsize      = (TSIZE_W'(cnt_now) << 8) + (TSIZE_W'(cnt_now) << 3);
    ds_now     = DS_W'(tsize) + DS_W'(rtv_pkg::HEADER_BYTES);
    err_count  = (cnt_now == '0) || (cnt_now > CNT_W'(MAX_ENTRIES));
    err_table  = (file_span >= SPAN_W'(rtv_pkg::HEADER_BYTES)) &&
                 (SPAN_W'(ds_now) > file_span);
  end

  // entry checks at the last record byte
  always_comb begin
    end_sum   = FPOS_W'(ds_r) + FPOS_W'(off_now) + FPOS_W'(cur_size);
    err_chain = (CHAIN_W'(off_now) != cur_chain);
    err_over  = (FPOS_W'(file_span) >= FPOS_W'(ds_r)) && (end_sum > FPOS_W'(file_span));
    last      = ((CHAIN_W'(cur_ent) + CHAIN_W'(1)) >= CHAIN_W'(cur_count));
  end

  // next state and classified transaction
  always_comb begin
    pos_nxt      = pos_r;
    in_table_nxt = in_table_r;
    ent_nxt      = ent_r;
    count_nxt    = count_r;
    size_nxt     = size_r;
    off_nxt      = off_r;
    chain_nxt    = chain_r;
    halted_nxt   = halted_r;
    ds_nxt       = ds_r;
    q_push       = 1'b0;
    q_item       = '0;
    q_item.status = rtv_pkg::ST_OK;
    if (acc) begin
      pos_nxt      = cur_pos;
      in_table_nxt = cur_in_table;
      ent_nxt      = cur_ent;
      count_nxt    = cur_count;
      size_nxt     = cur_size;
      off_nxt      = cur_off;
      chain_nxt    = cur_chain;
      halted_nxt   = cur_halted;
      if (span_short) begin
        q_push        = 1'b1;
        q_item.status = rtv_pkg::ST_SPAN_SHORT;
        halted_nxt    = 1'b1;
      end else if (!cur_halted) begin
        if (!cur_in_table) begin
          count_nxt = cnt_now;
          if (magic_bad) begin
            q_push        = 1'b1;
            q_item.status = rtv_pkg::ST_BAD_MAGIC;
            halted_nxt    = 1'b1;
          end else if (cur_pos >= POS_HDR_LAST) begin
            if (err_count) begin
              q_push        = 1'b1;
              q_item.status = rtv_pkg::ST_BAD_COUNT;
              halted_nxt    = 1'b1;
            end else if (err_table) begin
              q_push        = 1'b1;
              q_item.status = rtv_pkg::ST_TABLE_BIG;
              halted_nxt    = 1'b1;
            end else begin
              in_table_nxt = 1'b1;
              pos_nxt      = '0;
              ent_nxt      = '0;
              chain_nxt    = '0;
              ds_nxt       = ds_now;
            end
          end else begin
            pos_nxt = cur_pos + POS_W'(1);
          end
        end else begin
          size_nxt = size_now;
          off_nxt  = off_now;
          if (cur_pos < POS_ENT_LAST) begin
            pos_nxt = cur_pos + POS_W'(1);
          end else if (err_chain) begin
            q_push             = 1'b1;
            q_item.status      = rtv_pkg::ST_CHAIN_BAD;
            q_item.entry_index = cur_ent;
            halted_nxt         = 1'b1;
          end else if (err_over) begin
            q_push             = 1'b1;
            q_item.status      = rtv_pkg::ST_OVERRUN;
            q_item.entry_index = cur_ent;
            halted_nxt         = 1'b1;
          end else begin
            q_push             = 1'b1;
            q_item.entry_index = cur_ent;
            q_item.entry_size  = cur_size;
            q_item.rel_offset  = off_now;
            q_item.data_start  = ds_r;
            q_item.final_entry = last;
            chain_nxt          = CHAIN_W'(off_now) + CHAIN_W'(cur_size);
            pos_nxt            = '0;
            ent_nxt            = cur_ent + IDX_W'(1);
            halted_nxt         = last;
          end
        end
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      in_table_r <= 1'b0;
      ent_r      <= '0;
      count_r    <= '0;
      size_r     <= '0;
      off_r      <= '0;
      chain_r    <= '0;
      halted_r   <= 1'b1;
    end else begin
      pos_r      <= pos_nxt;
      in_table_r <= in_table_nxt;
      ent_r      <= ent_nxt;
      count_r    <= count_nxt;
      size_r     <= size_nxt;
      off_r      <= off_nxt;
      chain_r    <= chain_nxt;
      halted_r   <= halted_nxt;
    end
  end

  // payload register
  always_ff @(posedge clk) begin
    ds_r <= ds_nxt;
  end

endmodule

`default_nettype wire

FILE: rtl/rtv_queue.sv
// rtv_queue: short flop-based queue between the parser front and the result back
// depends on rtv_pkg
`default_nettype none

module rtv_queue #(
  parameter int unsigned DEPTH = rtv_pkg::Q_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire rtv_pkg::q_item_t push_item,
  output logic                  full,
  input  wire logic             pop,
  output rtv_pkg::q_item_t      pop_item,
  output logic                  empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  rtv_pkg::q_item_t  mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_item = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage write
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  // queue must never be written full or read empty
  assert property (@(posedge clk) disable iff (!rst_n) push |-> (!full || pop))
    else $error("rtv_queue: push into full queue");
  assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("rtv_queue: pop from empty queue");

endmodule

`default_nettype wire

FILE: rtl/rtv_back.sv
// rtv_back: takes classified transactions from the queue, forms absolute
// positions and holds the result in the output register
// depends on rtv_pkg
`default_nettype none

module rtv_back (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [rtv_pkg::SPAN_W-1:0] base_offset,
  input  wire logic                       q_empty,
  input  wire rtv_pkg::q_item_t           q_item,
  output logic                            q_pop,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output rtv_pkg::out_item_t              out_item
);

  localparam int unsigned FPOS_W = rtv_pkg::FPOS_W;

  logic               out_valid_r, out_valid_nxt;
  rtv_pkg::out_item_t out_item_r, out_item_nxt;
  logic [FPOS_W-1:0]  rec_off;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // output register free or being drained this cycle
  assign q_pop = !q_empty && (!out_valid_r || !out_stall);

  // position arithmetic; error results carry zero positions
  always_comb begin
    rec_off = (FPOS_W'(q_item.entry_index) << 8) + (FPOS_W'(q_item.entry_index) << 3);
    out_item_nxt                = out_item_r;
    out_valid_nxt               = out_valid_r && out_stall;
    if (q_pop) begin
      out_valid_nxt               = 1'b1;
      out_item_nxt.status         = q_item.status;
      out_item_nxt.entry_index    = q_item.entry_index;
      out_item_nxt.entry_size     = q_item.entry_size;
      out_item_nxt.final_entry    = q_item.final_entry;
      out_item_nxt.data_position  = '0;
      out_item_nxt.table_position = '0;
      if (q_item.status == rtv_pkg::ST_OK) begin
        out_item_nxt.data_position  = FPOS_W'(base_offset) + FPOS_W'(q_item.data_start) +
                                      FPOS_W'(q_item.rel_offset);
        out_item_nxt.table_position = FPOS_W'(base_offset) +
                                      FPOS_W'(rtv_pkg::HEADER_BYTES) + rec_off;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  // error results never carry positions, final flag only on a good entry
  assert property (@(posedge clk) disable iff (!rst_n)
                   (out_valid && out_item.status != rtv_pkg::ST_OK) |->
                   (out_item.data_position == '0 && out_item.table_position == '0))
    else $error("rtv_back: error result with nonzero position");
  assert property (@(posedge clk) disable iff (!rst_n)
                   (out_valid && out_item.final_entry) |-> (out_item.status == rtv_pkg::ST_OK))
    else $error("rtv_back: final flag on error result");

endmodule

`default_nettype wire

FILE: rtl/resource_table_validator_unit.sv
// resource_table_validator_unit: top level; configuration registers, parser
// front, transaction queue and result back
// depends on rtv_pkg, rtv_front, rtv_queue, rtv_back
//
//  channel  ports                                 transaction
//  in       in_valid, in_stall, in_item           one container byte + start flag
//  out      out_valid, out_stall, out_item        one entry result or error status
//  cfg      psel, penable, pwrite, paddr, pwdata,  64-bit register access,
//           prdata, pready                         file_span at 0, base_offset at 8
//
// one byte is accepted per cycle while in_stall is low; the front decides each byte in its own cycle
// a result passes through the queue storage and then the output register before it shows on out_valid
// in_stall rises only when the queue is full, i.e. the output side has stalled
// reset leaves the block halted until a byte with start_flag set arrives
// configuration registers reset to zero
`default_nettype none

module resource_table_validator_unit #(
  parameter int unsigned MAX_ENTRIES = rtv_pkg::MAX_ENTRIES_DEF,
  parameter int unsigned Q_DEPTH     = rtv_pkg::Q_DEPTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire rtv_pkg::in_item_t           in_item,
  output logic                             in_stall,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output rtv_pkg::out_item_t               out_item,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [rtv_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [rtv_pkg::DATA_W-1:0]  pwdata,
  output logic [rtv_pkg::DATA_W-1:0]       prdata,
  output logic                             pready
);

  localparam int unsigned SPAN_W = rtv_pkg::SPAN_W;
  localparam int unsigned DATA_W = rtv_pkg::DATA_W;

  logic [SPAN_W-1:0]  file_span_r, file_span_nxt;
  logic [SPAN_W-1:0]  base_offset_r, base_offset_nxt;
  rtv_pkg::reg_idx_t  reg_sel;
  logic               cfg_wr;

  logic               q_push, q_full, q_pop, q_empty;
  rtv_pkg::q_item_t   q_push_item, q_pop_item;

  // register access decode
  assign pready  = 1'b1;
  assign reg_sel = rtv_pkg::reg_idx_t'(paddr[3]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    file_span_nxt   = file_span_r;
    base_offset_nxt = base_offset_r;
    prdata          = '0;
    unique case (reg_sel)
      rtv_pkg::REG_FILE_SPAN: begin
        prdata = DATA_W'(file_span_r);
        if (cfg_wr) begin
          file_span_nxt = pwdata[SPAN_W-1:0];
        end
      end
      rtv_pkg::REG_BASE_OFFSET: begin
        prdata = DATA_W'(base_offset_r);
        if (cfg_wr) begin
          base_offset_nxt = pwdata[SPAN_W-1:0];
        end
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      file_span_r   <= '0;
      base_offset_r <= '0;
    end else begin
      file_span_r   <= file_span_nxt;
      base_offset_r <= base_offset_nxt;
    end
  end

  // byte parser and checker
  rtv_front #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .in_stall  (in_stall),
    .file_span (file_span_r),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_push_item)
  );

  // decoupling queue
  rtv_queue #(
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_pop_item),
    .empty     (q_empty)
  );

  // result formation and output register
  rtv_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .base_offset (base_offset_r),
    .q_empty     (q_empty),
    .q_item      (q_pop_item),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item)
  );

  // no result comes out of reset, and the front never pushes into a full queue
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("top: result valid right after reset");
  assert property (@(posedge clk) disable iff (!rst_n) q_full |-> !q_push)
    else $error("top: front pushed while queue full");

endmodule

`default_nettype wire

FILE: dv/resource_table_validator_unit_test.sv
`timescale 1ns / 1ps
// resource_table_validator_unit_test: directed and random container streams, a byte-level
// predictor of the validator and a result checker; depends on rtv_pkg and the DUT top level

module resource_table_validator_unit_test;
  import rtv_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned RANDOM_BYTES = 1550;
  localparam int unsigned RANDOM_RESULTS = 40;
  localparam logic [ADDR_W-1:0] FILE_SPAN_ADDR = {REG_FILE_SPAN, 3'b000};
  localparam logic [ADDR_W-1:0] BASE_OFFSET_ADDR = {REG_BASE_OFFSET, 3'b000};
  localparam logic [SPAN_W-1:0] SPAN_MAX = '1;
  // container signature, first byte in the top lane
  localparam logic [8*MAGIC_BYTES-1:0] SIGNATURE = 80'h7C43_4354_6673_322E_307C;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic out_valid;
  logic out_stall;
  in_item_t in_item;
  out_item_t out_item;
  logic psel;
  logic penable;
  logic pwrite;
  logic pready;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;

  // predictor copy of registers and parse state
  logic [SPAN_W-1:0] span_q;
  logic [SPAN_W-1:0] base_q;
  int unsigned rd_pos;
  bit in_tbl;
  logic [IDX_W-1:0] ent_idx;
  logic [CNT_W-1:0] members;
  logic [SIZE_W-1:0] size_acc;
  logic [OFF_W-1:0] off_acc;
  logic [CHAIN_W-1:0] chain_next;
  bit parked;

  out_item_t pending_results[$];
  logic [7:0] byte_stream[$];
  int unsigned fail_count;
  int unsigned parsed_bytes;
  int unsigned results_made;
  bit calm;

  resource_table_validator_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_item  (in_item),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void reset_parse();
    rd_pos = 0;
    in_tbl = 1'b0;
    ent_idx = '0;
    members = '0;
    size_acc = '0;
    off_acc = '0;
    chain_next = '0;
  endfunction

  // an error reports once and parks the parser until the next start
  function automatic void flag_error(status_t code, logic [IDX_W-1:0] idx);
    out_item_t r;
    r = '0;
    r.status = code;
    r.entry_index = idx;
    pending_results.push_back(r);
    results_made++;
    parked = 1'b1;
  endfunction

  function automatic void predict_byte(in_item_t it);
    logic [7:0] b;
    longint unsigned tbl_bytes;
    longint unsigned data_start;
    longint unsigned remain;
    longint unsigned off;
    longint unsigned sz;
    out_item_t r;
    b = it.data_byte;
    if (it.start_flag) begin
      reset_parse();
      parked = 1'b0;
      if (span_q < HEADER_BYTES) begin
        flag_error(ST_SPAN_SHORT, '0);
        return;
      end
    end
    if (parked) return;
    parsed_bytes++;

    // header: signature, ignored bytes, little-endian member count
    if (!in_tbl) begin
      if (rd_pos < MAGIC_BYTES) begin
        if (b != SIGNATURE[8*MAGIC_BYTES-1-8*rd_pos -: 8]) begin
          flag_error(ST_BAD_MAGIC, '0);
          return;
        end
      end else if (rd_pos >= COUNT_POS && rd_pos < HEADER_BYTES) begin
        members[8*(rd_pos-COUNT_POS) +: 8] = b;
      end
      if (rd_pos + 1 >= HEADER_BYTES) begin
        tbl_bytes = {32'd0, members} * ENTRY_BYTES;
        if (members == 0 || members > MAX_ENTRIES_DEF) begin
          flag_error(ST_BAD_COUNT, '0);
        end else if (tbl_bytes > {16'd0, span_q} - HEADER_BYTES) begin
          flag_error(ST_TABLE_BIG, '0);
        end else begin
          in_tbl = 1'b1;
          rd_pos = 0;
          ent_idx = '0;
          chain_next = '0;
        end
      end else begin
        rd_pos++;
      end
      return;
    end

    // table record: name skipped, then size and relative offset
    if (rd_pos >= NAME_BYTES && rd_pos < NAME_BYTES + 4) begin
      size_acc[8*(rd_pos-NAME_BYTES) +: 8] = b;
    end else if (rd_pos >= NAME_BYTES + 4 && rd_pos < NAME_BYTES + 8) begin
      off_acc[8*(rd_pos-NAME_BYTES-4) +: 8] = b;
    end
    if (rd_pos + 1 < ENTRY_BYTES) begin
      rd_pos++;
      return;
    end

    // record complete: chain and bounds checks
    data_start = HEADER_BYTES + {32'd0, members} * ENTRY_BYTES;
    remain = {16'd0, span_q} - data_start;
    off = {32'd0, off_acc};
    sz = {32'd0, size_acc};
    if (off != {31'd0, chain_next}) begin
      flag_error(ST_CHAIN_BAD, ent_idx);
      return;
    end
    if (off > remain || sz > remain - off) begin
      flag_error(ST_OVERRUN, ent_idx);
      return;
    end
    r = '0;
    r.status = ST_OK;
    r.entry_index = ent_idx;
    r.entry_size = size_acc;
    r.data_position = {16'd0, base_q} + data_start + off;
    r.table_position = {16'd0, base_q} + HEADER_BYTES + {46'd0, ent_idx} * ENTRY_BYTES;
    r.final_entry = ({14'd0, ent_idx} + 32'd1) >= members;
    pending_results.push_back(r);
    results_made++;
    chain_next = off + sz;
    rd_pos = 0;
    ent_idx = ent_idx + 1'b1;
    if (r.final_entry) parked = 1'b1;
  endfunction

  // ---------------------------------------------------------------- checker

  function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  function automatic void compare_result(out_item_t got);
    out_item_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: result with none expected: actual status %0d index %0h size %0h",
               $time, got.status, got.entry_index, got.entry_size);
      fail_count++;
      return;
    end
    want = pending_results.pop_front();
    compare_field("status", want.status, got.status);
    compare_field("entry_index", want.entry_index, got.entry_index);
    compare_field("entry_size", want.entry_size, got.entry_size);
    compare_field("data_position", want.data_position, got.data_position);
    compare_field("table_position", want.table_position, got.table_position);
    compare_field("final_entry", want.final_entry, got.final_entry);
  endfunction

  // sample both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) compare_result(out_item);
      if (in_valid && !in_stall) predict_byte(in_item);
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    out_stall <= rst_n && !calm && ($urandom_range(99) < 26);
  end

  // ---------------------------------------------------------------- stream building

  function automatic void add_le32(logic [31:0] v);
    for (int i = 0; i < 4; i++) byte_stream.push_back(v[8*i +: 8]);
  endfunction

  function automatic void add_header(logic [31:0] cnt);
    for (int i = 0; i < MAGIC_BYTES; i++)
      byte_stream.push_back(SIGNATURE[8*MAGIC_BYTES-1-8*i -: 8]);
    for (int i = MAGIC_BYTES; i < COUNT_POS; i++) byte_stream.push_back($urandom);
    add_le32(cnt);
  endfunction

  function automatic void add_record(logic [31:0] sz, logic [31:0] off);
    for (int i = 0; i < NAME_BYTES; i++) byte_stream.push_back($urandom);
    add_le32(sz);
    add_le32(off);
  endfunction

  function automatic void trim_stream(int unsigned keep);
    while (byte_stream.size() > keep) byte_stream.delete(byte_stream.size() - 1);
  endfunction

  function automatic void add_noise(int unsigned n);
    for (int i = 0; i < n; i++) byte_stream.push_back($urandom);
  endfunction

  // ---------------------------------------------------------------- drivers

  // one input transaction, random idle cycles ahead of it
  task automatic feed_byte(input logic [7:0] b, input logic s);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item.data_byte <= b;
    in_item.start_flag <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic stream_bytes(input bit with_start);
    for (int i = 0; i < byte_stream.size(); i++)
      feed_byte(byte_stream[i], with_start && i == 0);
    byte_stream.delete();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_quiet();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write one register, then read it back in a back-to-back transfer
  task automatic reg_write_verify(input logic [ADDR_W-1:0] addr, input logic [SPAN_W-1:0] val);
    logic [15:0] upper;
    upper = $urandom;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= {upper, val};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == FILE_SPAN_ADDR) span_q = val;
    else base_q = val;
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[SPAN_W-1:0] !== val) begin
      $display("%0t: register %0h readback: expected %0h, actual %0h",
               $time, addr, val, prdata[SPAN_W-1:0]);
      fail_count++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic program_regs(input logic [SPAN_W-1:0] span, input logic [SPAN_W-1:0] base);
    wait_quiet();
    reg_write_verify(FILE_SPAN_ADDR, span);
    reg_write_verify(BASE_OFFSET_ADDR, base);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_span_short();
    // span zero from reset: the start byte itself is rejected
    byte_stream.push_back(SIGNATURE[8*MAGIC_BYTES-1 -: 8]);
    stream_bytes(1'b1);
    // parked: bytes without a start are dropped
    add_noise(4);
    stream_bytes(1'b0);
    program_regs(HEADER_BYTES - 1, '0);
    add_header(1);
    stream_bytes(1'b1);
    // header fits but no room for a single record
    program_regs(HEADER_BYTES, '0);
    add_header(1);
    stream_bytes(1'b1);
  endtask

  task automatic test_signature();
    program_regs(SPAN_MAX, '0);
    byte_stream.push_back(8'h00);
    stream_bytes(1'b1);
    add_header(1);
    byte_stream[MAGIC_BYTES-1] = byte_stream[MAGIC_BYTES-1] ^ 8'h80;
    stream_bytes(1'b1);
  endtask

  task automatic test_member_count();
    // largest legal count passes the header, restart part-way into the table
    add_header(MAX_ENTRIES_DEF);
    add_noise(40);
    stream_bytes(1'b1);
    add_header(0);
    stream_bytes(1'b1);
    add_header(MAX_ENTRIES_DEF + 1);
    stream_bytes(1'b1);
    add_header(32'hFFFF_FFFF);
    stream_bytes(1'b1);
  endtask

  task automatic test_table_fit();
    program_regs(HEADER_BYTES + 2 * ENTRY_BYTES - 1, '0);
    add_header(2);
    stream_bytes(1'b1);
    // exact fit with empty payloads, then trailing bytes after the last record
    program_regs(HEADER_BYTES + 2 * ENTRY_BYTES, '0);
    add_header(2);
    add_record(0, 0);
    add_record(0, 0);
    add_noise(6);
    stream_bytes(1'b1);
    // payload one byte past the end of the file
    add_header(1);
    add_record(ENTRY_BYTES + 1, 0);
    stream_bytes(1'b1);
  endtask

  task automatic test_entry_chain();
    program_regs(SPAN_MAX, SPAN_MAX);
    calm = 1'b1;
    // cursor crosses 32 bits, so the third offset cannot chain
    add_header(3);
    add_record(32'hFFFF_FFFF, 0);
    add_record(1, 32'hFFFF_FFFF);
    add_record(0, 0);
    stream_bytes(1'b1);
    wait_quiet();
    calm = 1'b0;
  endtask

  task automatic pick_random_regs();
    logic [SPAN_W-1:0] span;
    logic [SPAN_W-1:0] base;
    case ($urandom_range(4))
      0: span = SPAN_MAX;
      1: span = HEADER_BYTES + ENTRY_BYTES * $urandom_range(1, 4) + $urandom_range(0, 3000);
      2: span = {$urandom, $urandom};
      3: span = $urandom_range(0, HEADER_BYTES - 1);
      default: span = HEADER_BYTES + ENTRY_BYTES * $urandom_range(1, 3) + $urandom_range(0, 40);
    endcase
    case ($urandom_range(2))
      0: base = '0;
      1: base = SPAN_MAX;
      default: base = {$urandom, $urandom};
    endcase
    program_regs(span, base);
  endtask

  function automatic longint unsigned pick_size(longint unsigned limit);
    longint unsigned cap;
    cap = (limit > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : limit;
    case ($urandom_range(4))
      0: return 0;
      1: return cap;
      2: return {$urandom, $urandom} % (cap + 1);
      default: return $urandom_range(0, 1000) % (cap + 1);
    endcase
  endfunction

  // well-formed container with random content, sometimes damaged or cut short
  task automatic send_random_container();
    int unsigned cnt;
    int unsigned rec;
    int unsigned keep;
    longint unsigned data_start;
    longint unsigned room;
    longint unsigned cursor;
    longint unsigned sz;
    int unsigned at;
    cnt = ($urandom_range(3) == 0) ? $urandom_range(2, 4) : 1;
    data_start = HEADER_BYTES + cnt * ENTRY_BYTES;
    room = (span_q >= data_start) ? span_q - data_start : 0;
    cursor = 0;
    add_header(cnt);
    for (int e = 0; e < cnt; e++) begin
      sz = pick_size((cursor > room) ? 0 : room - cursor);
      add_record(sz[31:0], cursor[31:0]);
      cursor = cursor + sz;
    end
    rec = $urandom_range(cnt - 1);
    at = HEADER_BYTES + rec * ENTRY_BYTES + NAME_BYTES + $urandom_range(7);
    case ($urandom_range(7))
      0, 1: byte_stream[at] = byte_stream[at] ^ (8'd1 << $urandom_range(7));
      2: trim_stream($urandom_range(1, byte_stream.size() - 1));
      default: ;
    endcase
    // bytes past a header-level error would only be ignored
    keep = byte_stream.size();
    if (span_q < HEADER_BYTES) keep = 1;
    else if (span_q - HEADER_BYTES < cnt * ENTRY_BYTES && keep > HEADER_BYTES)
      keep = HEADER_BYTES;
    trim_stream(keep);
    stream_bytes(1'b1);
  endtask

  task automatic test_random();
    int unsigned bytes_at_start;
    int unsigned results_at_start;
    int unsigned iter;
    int unsigned pick;
    bytes_at_start = parsed_bytes;
    results_at_start = results_made;
    iter = 0;
    while (parsed_bytes - bytes_at_start < RANDOM_BYTES ||
           results_made - results_at_start < RANDOM_RESULTS) begin
      if ($urandom_range(3) == 0) pick_random_regs();
      calm = (iter >= 20 && iter < 26);
      pick = $urandom_range(99);
      if (pick < 35) begin
        send_random_container();
      end else if (pick < 60) begin
        // header-level count cases
        case ($urandom_range(4))
          0: add_header(0);
          1: add_header(MAX_ENTRIES_DEF + 1 + $urandom_range(0, 1000));
          2: add_header($urandom);
          3: add_header(MAX_ENTRIES_DEF);
          default: add_header($urandom_range(1, 8));
        endcase
        stream_bytes(1'b1);
      end else if (pick < 75) begin
        add_header(1);
        at = $urandom_range(MAGIC_BYTES - 1);
        byte_stream[at] = byte_stream[at] ^ (8'd1 << $urandom_range(7));
        stream_bytes(1'b1);
      end else if (pick < 88) begin
        add_noise($urandom_range(1, 12));
        stream_bytes(1'b1);
      end else begin
        add_noise($urandom_range(1, 8));
        stream_bytes(1'b0);
      end
      iter++;
    end
    calm = 1'b0;
  endtask

  int unsigned at;

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    out_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    span_q = '0;
    base_q = '0;
    reset_parse();
    parked = 1'b1;
    calm = 1'b0;
    fail_count = 0;
    parsed_bytes = 0;
    results_made = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_span_short();
    test_signature();
    test_member_count();
    test_table_fit();
    test_entry_chain();
    test_random();
    wait_quiet();

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/rtv_pkg.sv
rtl/rtv_front.sv
rtl/rtv_queue.sv
rtl/rtv_back.sv
rtl/resource_table_validator_unit.sv
dv/resource_table_validator_unit_test.sv
